/* src/murmur64a_stream_hasher_assert.svh */
// Assertion macros shared by the checker of the stream hasher.
`ifndef MURMUR64A_STREAM_HASHER_ASSERT_SVH
`define MURMUR64A_STREAM_HASHER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define MMH_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define MMH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/mmh_pkg.sv */
// Types, constants and helpers shared by the stream hasher modules.
package mmh_pkg;

	localparam logic [63:0] MIX_MUL    = 64'hC6A4A7935BD1E995;
	localparam logic [63:0] SEED_RESET = 64'd3782874213;
	localparam int unsigned MIX_SHIFT  = 47;

	// What the back end has to do with the word of one queued transaction.
	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_PART,
		KIND_FULL
	} kind_t;

	typedef struct packed {
		logic [63:0] word;
		kind_t       kind;
		logic        first;
		logic        last;
		logic [63:0] len;
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED,
		ST_MIX1,
		ST_MIX2,
		ST_XOR,
		ST_FOLD,
		ST_FIN,
		ST_EMIT
	} back_state_t;

	// Step that follows once the hash is seeded (or right away when not first).
	function automatic back_state_t dispatch(input kind_t kind, input logic last);
		back_state_t nxt;
		unique case (kind)
			KIND_FULL: nxt = ST_MIX1;
			KIND_PART: nxt = ST_XOR;
			default:   nxt = last ? ST_FIN : ST_IDLE;
		endcase
		return nxt;
	endfunction

	function automatic logic [63:0] xor_shift(input logic [63:0] v);
		return v ^ (v >> MIX_SHIFT);
	endfunction

endpackage

/* src/murmur64a_stream_hasher.sv */
// Each 64-bit multiply runs as three partial products on the shared 32x32 multiplier.
// A middle full word takes a pop and three multiplies; a partial word takes a pop, an XOR and one.
// A first transaction adds a seeding multiply, a last one adds a finishing multiply and output.
// Throughput is set by the single multiplier; the queue takes new transactions until it is full.
// Reset (arst_n low, asynchronous) empties the queue, closes any message, drops any result
// and loads the seed register with its default.
module murmur64a_stream_hasher #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] data_word,
	input  logic [3:0]  byte_count,
	input  logic        first_item,
	input  logic        last_item,
	input  logic [63:0] msg_len,
	// result stream
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] hash_value,
	// seed register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [63:0] cfg_data
);
	import mmh_pkg::*;

	logic        push;
	op_t         push_op;
	op_t         head;
	logic        q_empty;
	logic        q_full;
	logic        pop;
	logic [63:0] seed_q;

	// The seed register takes a write in any cycle; it is sampled when a message is seeded.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
		end else if (cfg_valid && cfg_ready) begin
			seed_q <= cfg_data;
		end
	end

	// Front end: accept each transaction, drop it if no message is open, and queue the rest
	// with a partial word already masked to its valid bytes.
	mmh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_word  (data_word),
		.byte_count (byte_count),
		.first_item (first_item),
		.last_item  (last_item),
		.msg_len    (msg_len),
		.q_full     (q_full),
		.push       (push),
		.push_op    (push_op)
	);

	// Queue: decouple acceptance from the multi-cycle hash steps.
	mmh_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head    (head),
		.empty   (q_empty),
		.full    (q_full)
	);

	// Back end: seed, mix, fold and finish; the result register holds while stalled.
	mmh_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed       (seed_q),
		.head       (head),
		.q_empty    (q_empty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hash_value (hash_value)
	);

endmodule

/* src/mmh_front.sv */
// Front end: accepts input transactions, drops those outside a message, classifies words.
module mmh_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [63:0]   data_word,
	input  logic [3:0]    byte_count,
	input  logic          first_item,
	input  logic          last_item,
	input  logic [63:0]   msg_len,
	input  logic          q_full,
	output logic          push,
	output mmh_pkg::op_t  push_op
);
	import mmh_pkg::*;

	logic        in_msg_q;
	logic        accept;
	logic [63:0] mask;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign push     = accept && (first_item || in_msg_q);

	// Low-byte mask for a partial word of one to seven bytes.
	assign mask = ~(64'hFFFF_FFFF_FFFF_FFFF << {byte_count[2:0], 3'b000});

	always_comb begin
		push_op.first = first_item;
		push_op.last  = last_item;
		push_op.len   = msg_len;
		if (byte_count[3]) begin
			push_op.kind = KIND_FULL;
			push_op.word = data_word;
		end else if (byte_count[2:0] == 3'd0) begin
			push_op.kind = KIND_NONE;
			push_op.word = data_word;
		end else begin
			push_op.kind = KIND_PART;
			push_op.word = data_word & mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_msg_q <= 1'b0;
		end else if (push) begin
			in_msg_q <= !last_item;
		end
	end

endmodule

/* src/mmh_fifo.sv */
// Short queue of classified transactions between front and back end.
module mmh_fifo #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mmh_pkg::op_t  push_op,
	input  logic          pop,
	output mmh_pkg::op_t  head,
	output logic          empty,
	output logic          full
);
	import mmh_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	op_t           mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign empty   = (count_q == CW'(0));
	assign full    = (count_q == CW'(DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? AW'(0) : p + AW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* src/mmh_mul.sv */
// Multiply by the mixing constant modulo 2^64, one 32x32 partial product per cycle.
module mmh_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] operand,
	output logic        done,
	output logic [63:0] product
);
	import mmh_pkg::*;

	logic [63:0] a_q;
	logic [63:0] acc_q;
	logic [1:0]  step_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] x;
	logic [31:0] y;
	logic [63:0] p;

	// Low half only: lo*lo in full, then the two cross terms into the upper word.
	always_comb begin
		unique case (step_q)
			2'd0: begin
				x = a_q[31:0];
				y = MIX_MUL[31:0];
			end
			2'd1: begin
				x = a_q[31:0];
				y = MIX_MUL[63:32];
			end
			default: begin
				x = a_q[63:32];
				y = MIX_MUL[31:0];
			end
		endcase
		p = {32'd0, x} * {32'd0, y};
	end

	assign done    = done_q;
	assign product = acc_q;

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= operand;
		end
		if (busy_q) begin
			if (step_q == 2'd0) begin
				acc_q <= p;
			end else begin
				acc_q[63:32] <= acc_q[63:32] + p[31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 2'd0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= 2'd0;
			done_q <= 1'b0;
		end else if (busy_q) begin
			step_q <= step_q + 2'd1;
			if (step_q == 2'd2) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

endmodule

/* src/mmh_back.sv */
// Back end: sequences the hash recurrence over the shared multiplier and holds the result.
module mmh_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [63:0]   seed,
	input  mmh_pkg::op_t  head,
	input  logic          q_empty,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [63:0]   hash_value
);
	import mmh_pkg::*;

	back_state_t st_q;
	back_state_t st_d;
	op_t         op_q;
	logic [63:0] h_q;
	logic [63:0] k_q;
	logic [63:0] hash_q;
	logic        out_valid_q;
	logic        started_q;
	logic        mul_start;
	logic [63:0] mul_operand;
	logic        mul_done;
	logic [63:0] mul_product;
	logic        out_load;

	mmh_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.operand (mul_operand),
		.done    (mul_done),
		.product (mul_product)
	);

	always_comb begin
		st_d        = st_q;
		pop         = 1'b0;
		mul_start   = 1'b0;
		mul_operand = h_q;
		out_load    = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				if (!q_empty) begin
					pop  = 1'b1;
					st_d = head.first ? ST_SEED : dispatch(head.kind, head.last);
				end
			end
			ST_SEED: begin
				mul_operand = op_q.len;
				mul_start   = !started_q;
				if (mul_done) begin
					st_d = dispatch(op_q.kind, op_q.last);
				end
			end
			ST_MIX1: begin
				mul_operand = op_q.word;
				mul_start   = !started_q;
				if (mul_done) begin
					st_d = ST_MIX2;
				end
			end
			ST_MIX2: begin
				mul_operand = k_q;
				mul_start   = !started_q;
				if (mul_done) begin
					st_d = ST_FOLD;
				end
			end
			ST_XOR: begin
				st_d = ST_FOLD;
			end
			ST_FOLD: begin
				mul_operand = h_q;
				mul_start   = !started_q;
				if (mul_done) begin
					st_d = op_q.last ? ST_FIN : ST_IDLE;
				end
			end
			ST_FIN: begin
				mul_operand = xor_shift(h_q);
				mul_start   = !started_q;
				if (mul_done) begin
					st_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					st_d     = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
			h_q         <= '0;
		end else begin
			st_q <= st_d;
			if (mul_done) begin
				started_q <= 1'b0;
			end else if (mul_start) begin
				started_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (mul_done && st_q == ST_SEED) begin
				h_q <= seed ^ mul_product;
			end else if (mul_done && st_q == ST_MIX2) begin
				h_q <= h_q ^ mul_product;
			end else if (mul_done && st_q == ST_FOLD) begin
				h_q <= mul_product;
			end else if (st_q == ST_XOR) begin
				h_q <= h_q ^ op_q.word;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_q <= head;
		end
		if (mul_done && (st_q == ST_MIX1 || st_q == ST_FIN)) begin
			k_q <= xor_shift(mul_product);
		end
		if (out_load) begin
			hash_q <= k_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign hash_value = hash_q;

endmodule

/* src/mmh_checker.sv */
// Port-level checks of the stream hasher and their binding to the top level.
`include "murmur64a_stream_hasher_assert.svh"

module mmh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] hash_value
);

	// Hold a stalled result.
	`MMH_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
	`MMH_ASSERT_NEXT(a_hash_stable, out_valid && out_stall, $stable(hash_value), "stalled hash changed")
	// The queue fills only through an accepted transaction.
	`MMH_ASSERT_NOW(a_stall_cause, $rose(in_stall), $past(in_valid && !in_stall), "stall without push")

endmodule

bind murmur64a_stream_hasher mmh_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.hash_value (hash_value)
);
